// ===== hw/rtl/vvrm_pkg.sv =====
// Shared widths, types and helpers for the vector-to-vector rotation matrix unit.
package vvrm_pkg;

   // Field and datapath widths.
   localparam int InW      = 16;
   localparam int OutW     = 16;
   localparam int CfgW     = 32;
   localparam int ProdW    = 32;
   localparam int VW       = 33;
   localparam int EW       = 33;
   localparam int MagW     = 32;
   localparam int SqW      = 64;
   localparam int LenW     = 64;
   localparam int ShW      = 5;
   localparam int WW       = 15;
   localparam int PW       = 30;
   localparam int NumW     = 63;
   localparam int DenW     = 32;
   localparam int DivSteps = 33;
   localparam int QuoW     = DivSteps;
   localparam int TW       = 34;
   localparam int SumW     = 36;
   localparam int FracW    = 28;
   localparam int MatW     = 9 * OutW;
   localparam int Lanes    = 6;

   // Constants.
   localparam logic [CfgW-1:0]       ThresholdReset = 32'd268;
   localparam logic signed [EW:0]    OneQ28         = 34'sd268435456;
   localparam logic [OutW-1:0]       OneQ14         = 16'h4000;
   localparam logic [MatW-1:0]       IdentityMat    = {OneQ14, 16'h0000, 16'h0000, 16'h0000,
                                                       OneQ14, 16'h0000, 16'h0000, 16'h0000,
                                                       OneQ14};

   // Values that travel alongside the division lanes.
   typedef struct packed {
      logic                 deg;
      logic signed [EW-1:0] e;
      logic signed [VW-1:0] v0;
      logic signed [VW-1:0] v1;
      logic signed [VW-1:0] v2;
      logic [Lanes-1:0]     nsign;
   } side_type;

   // One finished result beat.
   typedef struct packed {
      logic            deg;
      logic [MatW-1:0] mat;
   } res_type;

   // Q.28 to Q.14, rounded half away from zero, then saturated.
   function automatic logic [OutW-1:0] to_q14(input logic signed [SumW-1:0] x);
      logic [SumW-1:0] m;
      logic [SumW-1:0] r;
      m = x[SumW-1] ? SumW'(-x) : SumW'(x);
      r = (m + SumW'(8192)) >> 14;
      if (x[SumW-1]) begin
         to_q14 = (r > SumW'(32768)) ? 16'h8000 : OutW'(-r);
      end else begin
         to_q14 = (r > SumW'(32767)) ? 16'h7fff : r[OutW-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/vvrm_div_lane.sv =====
// Pipelined restoring divider lane, one quotient bit per stage.
module vvrm_div_lane import vvrm_pkg::*; (
   input  logic            clock,
   input  logic            en,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic [QuoW-1:0] quo
);

   logic [DenW-1:0] rem_ff [DivSteps+1];
   logic [QuoW-1:0] dvd_ff [DivSteps+1];
   logic [QuoW-1:0] quo_ff [DivSteps+1];
   logic [DenW-1:0] den_ff [DivSteps+1];

   // Entry stage: the upper dividend bits form the first partial remainder.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DenW'(num[NumW-1:QuoW]);
         dvd_ff[0] <= num[QuoW-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den;
      end
   end

   // Each stage brings down one dividend bit and tries a subtraction.
   for (genvar k = 1; k <= DivSteps; k++) begin : g_step
      logic [DenW:0] trial;
      logic          fit;
      logic [DenW-1:0] rem_in;
      logic [QuoW-1:0] quo_in;
      assign trial  = {rem_ff[k-1], dvd_ff[k-1][DivSteps-k]};
      assign fit    = trial >= {1'b0, den_ff[k-1]};
      assign rem_in = fit ? DenW'(trial - {1'b0, den_ff[k-1]}) : trial[DenW-1:0];

      // Quotient so far with this stage's bit set in place.
      always_comb begin
         quo_in               = quo_ff[k-1];
         quo_in[DivSteps-k]   = fit;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            dvd_ff[k] <= dvd_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[DivSteps];

endmodule

// ===== hw/rtl/vector_to_vector_rotation_matrix_unit.sv =====
// Top level: rotation matrix turning a source unit vector onto a target one.
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_tvalid/req_tready  tdata: src_x,src_y,src_z,dst_x,dst_y,dst_z
//  rsp_      out        rsp_tvalid/rsp_tready  tdata: m00..m22, tuser: degenerate
//  csr_      in         csr_valid/csr_ready    csr_data: min_cross_length_sq
//
// One beat is accepted per cycle while the skid register is empty. Each beat passes
// seven arithmetic stages, then 34 stages of six parallel pipelined restoring
// dividers, then the output register. A skid register behind the output catches a
// finished beat during an output stall; the whole pipeline holds while it is full.
// Reset is synchronous, clears the valid bits and reloads the threshold's reset value.
module vector_to_vector_rotation_matrix_unit import vvrm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [6*InW-1:0] req_tdata,  // src_x, src_y, src_z, dst_x, dst_y, dst_z
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [MatW-1:0]  rsp_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic             rsp_tuser,  // degenerate
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CfgW-1:0]  csr_data
);

   logic en;
   logic [7:1] vld_ff;
   logic [DivSteps:0] lvld_ff;

   // Threshold register.
   logic [CfgW-1:0] thr_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThresholdReset;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // Input fields.
   logic signed [InW-1:0] sx, sy, sz, dx, dy, dz;
   assign sx = req_tdata[0*InW +: InW];
   assign sy = req_tdata[1*InW +: InW];
   assign sz = req_tdata[2*InW +: InW];
   assign dx = req_tdata[3*InW +: InW];
   assign dy = req_tdata[4*InW +: InW];
   assign dz = req_tdata[5*InW +: InW];

   // Stage 1: the nine component products.
   logic signed [ProdW-1:0] s1_p_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         s1_p_ff[0] <= sy * dz;
         s1_p_ff[1] <= sz * dy;
         s1_p_ff[2] <= sz * dx;
         s1_p_ff[3] <= sx * dz;
         s1_p_ff[4] <= sx * dy;
         s1_p_ff[5] <= sy * dx;
         s1_p_ff[6] <= sx * dx;
         s1_p_ff[7] <= sy * dy;
         s1_p_ff[8] <= sz * dz;
      end
   end

   // Stage 2: cross product v and dot product e.
   logic signed [VW-1:0] s2_v_ff [3];
   logic signed [EW-1:0] s2_e_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s2_v_ff[0] <= VW'(s1_p_ff[0]) - VW'(s1_p_ff[1]);
         s2_v_ff[1] <= VW'(s1_p_ff[2]) - VW'(s1_p_ff[3]);
         s2_v_ff[2] <= VW'(s1_p_ff[4]) - VW'(s1_p_ff[5]);
         s2_e_ff    <= EW'(s1_p_ff[6]) + EW'(s1_p_ff[7]) + EW'(s1_p_ff[8]);
      end
   end

   // Stage 3: magnitudes, their squares and the largest magnitude.
   logic [MagW-1:0] s3_a_in [3];
   logic [MagW-1:0] s3_a_ff [3];
   logic [SqW-1:0]  s3_sq_ff [3];
   logic [MagW-1:0] s3_mx_in, s3_mx_ff;
   logic signed [VW-1:0] s3_v_ff [3];
   logic signed [EW-1:0] s3_e_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_a_in[i] = s2_v_ff[i][VW-1] ? MagW'(-s2_v_ff[i]) : MagW'(s2_v_ff[i]);
      end
      s3_mx_in = s3_a_in[0];
      if (s3_a_in[1] > s3_mx_in) s3_mx_in = s3_a_in[1];
      if (s3_a_in[2] > s3_mx_in) s3_mx_in = s3_a_in[2];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s3_a_ff[i]  <= s3_a_in[i];
            s3_sq_ff[i] <= SqW'(s3_a_in[i]) * SqW'(s3_a_in[i]);
            s3_v_ff[i]  <= s2_v_ff[i];
         end
         s3_mx_ff <= s3_mx_in;
         s3_e_ff  <= s2_e_ff;
      end
   end

   // Stage 4: degenerate test, scaling shift and 1 - e.
   logic [LenW-1:0]      s4_len_in;
   logic                 s4_deg_in;
   logic [ShW-1:0]       s4_sh_in;
   logic signed [EW:0]   s4_ome_in;
   logic                 s4_deg_ff;
   logic [ShW-1:0]       s4_sh_ff;
   logic [MagW-1:0]      s4_a_ff [3];
   logic [MagW-1:0]      s4_mome_ff;
   logic                 s4_osign_ff;
   logic signed [VW-1:0] s4_v_ff [3];
   logic signed [EW-1:0] s4_e_ff;
   always_comb begin
      s4_len_in = s3_sq_ff[0] + s3_sq_ff[1] + s3_sq_ff[2];
      s4_deg_in = (s4_len_in == '0) || (s4_len_in < {4'b0, thr_ff, 28'b0});
      s4_sh_in  = '0;
      for (int i = WW; i < MagW; i++) begin
         if (s3_mx_ff[i]) s4_sh_in = ShW'(i - (WW - 1));
      end
      s4_ome_in = OneQ28 - (EW+1)'(s3_e_ff);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s4_deg_ff   <= s4_deg_in;
         s4_sh_ff    <= s4_sh_in;
         s4_a_ff     <= s3_a_ff;
         s4_v_ff     <= s3_v_ff;
         s4_e_ff     <= s3_e_ff;
         s4_osign_ff <= s4_ome_in[EW];
         s4_mome_ff  <= s4_ome_in[EW] ? MagW'(-s4_ome_in) : MagW'(s4_ome_in);
      end
   end

   // Stage 5: scaled vector w as magnitudes; the signs stay with v.
   logic [WW-1:0]        s5_w_ff [3];
   logic                 s5_deg_ff;
   logic [MagW-1:0]      s5_mome_ff;
   logic                 s5_osign_ff;
   logic signed [VW-1:0] s5_v_ff [3];
   logic signed [EW-1:0] s5_e_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s5_w_ff[i] <= WW'(s4_a_ff[i] >> s4_sh_ff);
         end
         s5_deg_ff   <= s4_deg_ff;
         s5_mome_ff  <= s4_mome_ff;
         s5_osign_ff <= s4_osign_ff;
         s5_v_ff     <= s4_v_ff;
         s5_e_ff     <= s4_e_ff;
      end
   end

   // Stage 6: the six products wi*wj and their signs.
   logic [PW-1:0]        s6_pr_ff [Lanes];
   logic [Lanes-1:0]     s6_psign_ff;
   logic                 s6_deg_ff;
   logic [MagW-1:0]      s6_mome_ff;
   logic                 s6_osign_ff;
   logic signed [VW-1:0] s6_v_ff [3];
   logic signed [EW-1:0] s6_e_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s6_pr_ff[0] <= PW'(s5_w_ff[0]) * PW'(s5_w_ff[0]);
         s6_pr_ff[1] <= PW'(s5_w_ff[1]) * PW'(s5_w_ff[1]);
         s6_pr_ff[2] <= PW'(s5_w_ff[2]) * PW'(s5_w_ff[2]);
         s6_pr_ff[3] <= PW'(s5_w_ff[0]) * PW'(s5_w_ff[1]);
         s6_pr_ff[4] <= PW'(s5_w_ff[0]) * PW'(s5_w_ff[2]);
         s6_pr_ff[5] <= PW'(s5_w_ff[1]) * PW'(s5_w_ff[2]);
         s6_psign_ff <= {s5_v_ff[1][VW-1] ^ s5_v_ff[2][VW-1],
                         s5_v_ff[0][VW-1] ^ s5_v_ff[2][VW-1],
                         s5_v_ff[0][VW-1] ^ s5_v_ff[1][VW-1], 3'b000};
         s6_deg_ff   <= s5_deg_ff;
         s6_mome_ff  <= s5_mome_ff;
         s6_osign_ff <= s5_osign_ff;
         s6_v_ff     <= s5_v_ff;
         s6_e_ff     <= s5_e_ff;
      end
   end

   // Stage 7: numerators (1 - e) * wi*wj and the divisor |w|^2.
   logic [NumW-2:0] s7_prod_ff [Lanes];
   logic [DenW-1:0] s7_lw_ff;
   side_type        s7_side_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Lanes; k++) begin
            s7_prod_ff[k] <= (NumW-1)'(s6_mome_ff) * (NumW-1)'(s6_pr_ff[k]);
         end
         s7_lw_ff         <= DenW'(s6_pr_ff[0]) + DenW'(s6_pr_ff[1]) + DenW'(s6_pr_ff[2]);
         s7_side_ff.deg   <= s6_deg_ff;
         s7_side_ff.e     <= s6_e_ff;
         s7_side_ff.v0    <= s6_v_ff[0];
         s7_side_ff.v1    <= s6_v_ff[1];
         s7_side_ff.v2    <= s6_v_ff[2];
         s7_side_ff.nsign <= s6_psign_ff ^ {Lanes{s6_osign_ff}};
      end
   end

   // Division lanes: rounded quotient of |numerator| + |w|^2 / 2 over |w|^2.
   logic [QuoW-1:0] quo [Lanes];
   for (genvar k = 0; k < Lanes; k++) begin : g_lane
      logic [NumW-1:0] num_in;
      assign num_in = NumW'(s7_prod_ff[k]) + NumW'(s7_lw_ff >> 1);
      vvrm_div_lane u_lane (
         .clock (clock),
         .en    (en),
         .num   (num_in),
         .den   (s7_lw_ff),
         .quo   (quo[k])
      );
   end

   // Side values follow the lanes stage by stage.
   side_type side_ff [DivSteps+1];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= s7_side_ff;
         for (int i = 1; i <= DivSteps; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         lvld_ff <= '0;
      end else if (en) begin
         vld_ff  <= {vld_ff[6:1], req_tvalid};
         lvld_ff <= {lvld_ff[DivSteps-1:0], vld_ff[7]};
      end
   end

   // Final assembly: signed terms, matrix entries, rounding and identity select.
   side_type              fin_side;
   logic signed [TW-1:0]  t [Lanes];
   logic signed [SumW-1:0] ee, v0, v1, v2;
   res_type               fin;
   logic                  fin_go;
   assign fin_side = side_ff[DivSteps];
   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         t[k] = fin_side.nsign[k] ? -TW'({1'b0, quo[k]}) : TW'({1'b0, quo[k]});
      end
      ee = SumW'(fin_side.e);
      v0 = SumW'(fin_side.v0);
      v1 = SumW'(fin_side.v1);
      v2 = SumW'(fin_side.v2);
      fin.deg = fin_side.deg;
      if (fin_side.deg) begin
         fin.mat = IdentityMat;
      end else begin
         fin.mat = {to_q14(ee + SumW'(t[2])),
                    to_q14(SumW'(t[5]) + v0),
                    to_q14(SumW'(t[4]) - v1),
                    to_q14(SumW'(t[5]) - v0),
                    to_q14(ee + SumW'(t[1])),
                    to_q14(SumW'(t[3]) + v2),
                    to_q14(SumW'(t[4]) + v1),
                    to_q14(SumW'(t[3]) - v2),
                    to_q14(ee + SumW'(t[0]))};
      end
   end
   assign fin_go = en && lvld_ff[DivSteps];

   // Output register with a skid register behind it.
   logic    out_vld_ff, skid_vld_ff;
   res_type out_ff, skid_ff;
   assign en = !skid_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_tready || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_ff      <= skid_ff;
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_ff      <= fin;
            out_vld_ff  <= fin_go;
         end
      end else if (fin_go) begin
         skid_ff     <= fin;
         skid_vld_ff <= 1'b1;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.mat;
   assign rsp_tuser  = out_ff.deg;

   // A beat in the skid register always has one ahead of it in the output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register full while output register empty");

   // A finished beat meeting a stalled output goes to the skid register.
   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      (fin_go && out_vld_ff && !rsp_tready) |=> skid_vld_ff)
      else $error("finished beat dropped during output stall");

   // A degenerate result carries the identity.
   a_deg_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == IdentityMat))
      else $error("degenerate result is not the identity");

endmodule
